// File: hw/rtl/ldpm_pkg.sv
// Shared types, register codes and fixed-point helpers for the lens distortion point map.
// No dependencies; every other file of the block imports this package.
package ldpm_pkg;

  localparam int QShift = 28;
  localparam logic signed [31:0] QOne = 32'sh1000_0000;

  // Register codes, equal to paddr[5:3].
  typedef enum logic [2:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_CENTER_X  = 3'd2,
    REG_CENTER_Y  = 3'd3,
    REG_RADIAL_K1 = 3'd4,
    REG_RADIAL_K2 = 3'd5,
    REG_RADIAL_K3 = 3'd6,
    REG_TANGENT   = 3'd7
  } ldpm_reg_e;

  typedef struct packed {
    logic [23:0]        focal_x;
    logic [23:0]        focal_y;
    logic [19:0]        center_x;
    logic [19:0]        center_y;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } ldpm_cfg_t;

  // Saturate to signed 32 bits; bit 32 of the result flags a clip.
  function automatic logic [32:0] sat_s36(input logic signed [35:0] v);
    logic [32:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -36'sh0_8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Q4.28 product: floor shift by 28, then saturate.
  function automatic logic [32:0] mulq_fin(input logic signed [63:0] p);
    logic signed [35:0] s;
    s = p[63:28];
    return sat_s36(s);
  endfunction

endpackage

// File: hw/rtl/ldpm_cfg.sv
// APB register file holding the focal lengths, principal point and coefficients.
// Depends on ldpm_pkg.
module ldpm_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output ldpm_pkg::ldpm_cfg_t cfg_o
);
  import ldpm_pkg::*;

  ldpm_cfg_t cfg_q, cfg_d;
  ldpm_reg_e sel;

  assign sel    = ldpm_reg_e'(paddr[5:3]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (sel)
        REG_FOCAL_X:   cfg_d.focal_x  = pwdata[23:0];
        REG_FOCAL_Y:   cfg_d.focal_y  = pwdata[23:0];
        REG_CENTER_X:  cfg_d.center_x = pwdata[19:0];
        REG_CENTER_Y:  cfg_d.center_y = pwdata[19:0];
        REG_RADIAL_K1: cfg_d.k1       = pwdata[31:0];
        REG_RADIAL_K2: cfg_d.k2       = pwdata[31:0];
        REG_RADIAL_K3: cfg_d.k3       = pwdata[31:0];
        REG_TANGENT: begin
          cfg_d.p1 = pwdata[31:0];
          cfg_d.p2 = pwdata[63:32];
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_FOCAL_X:   prdata = {40'd0, cfg_q.focal_x};
      REG_FOCAL_Y:   prdata = {40'd0, cfg_q.focal_y};
      REG_CENTER_X:  prdata = {44'd0, cfg_q.center_x};
      REG_CENTER_Y:  prdata = {44'd0, cfg_q.center_y};
      REG_RADIAL_K1: prdata = {32'd0, cfg_q.k1};
      REG_RADIAL_K2: prdata = {32'd0, cfg_q.k2};
      REG_RADIAL_K3: prdata = {32'd0, cfg_q.k3};
      REG_TANGENT:   prdata = {cfg_q.p2, cfg_q.p1};
      default:       prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{focal_x: 24'd256, focal_y: 24'd256, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: hw/rtl/ldpm_norm.sv
// Normalizer: (pixel*2^FRAC_BITS - center) * 2^28 / focal as saturated Q4.28.
// Pipelined restoring divider, one quotient bit per stage. Depends on ldpm_pkg.
module ldpm_norm #(
  parameter int PIXEL_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [PIXEL_BITS-1:0] pix_i,
  input  logic [19:0]           center_i,
  input  logic [23:0]           focal_i,
  output logic signed [31:0]    norm_o,
  output logic                  sat_o
);
  import ldpm_pkg::*;

  localparam int MW = (PIXEL_BITS + FRAC_BITS > 20) ? PIXEL_BITS + FRAC_BITS : 20;
  localparam int NW = MW + QShift;

  logic [23:0]   div;
  logic [MW+1:0] diff;
  logic [MW+1:0] mag;

  logic [23:0]   rem_q [NW+1];
  logic [NW-1:0] num_q [NW+1];
  logic [NW-1:0] quo_q [NW+1];
  logic          neg_q [NW+1];

  assign div  = (focal_i == 24'd0) ? 24'd1 : focal_i;
  assign diff = (MW+2)'({pix_i, {FRAC_BITS{1'b0}}}) - (MW+2)'(center_i);
  assign mag  = diff[MW+1] ? (~diff + (MW+2)'(1)) : diff;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      num_q[0] <= {mag[MW-1:0], {QShift{1'b0}}};
      neg_q[0] <= diff[MW+1];
    end
  end

  for (genvar s = 1; s <= NW; s++) begin : g_stage
    logic [24:0] part;
    logic        ge;
    logic [24:0] red;
    assign part = {rem_q[s-1], num_q[s-1][NW-1]};
    assign ge   = part >= {1'b0, div};
    assign red  = part - {1'b0, div};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? red[23:0] : part[23:0];
        quo_q[s] <= {quo_q[s-1][NW-2:0], ge};
        num_q[s] <= {num_q[s-1][NW-2:0], 1'b0};
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  logic [NW-1:0] q;
  assign q = quo_q[NW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[NW]) begin
        if (q > NW'(64'h8000_0000)) begin
          norm_o <= 32'sh8000_0000;
          sat_o  <= 1'b1;
        end else begin
          norm_o <= 32'(~q + NW'(1));
          sat_o  <= 1'b0;
        end
      end else begin
        if (q > NW'(64'h7FFF_FFFF)) begin
          norm_o <= 32'sh7FFF_FFFF;
          sat_o  <= 1'b1;
        end else begin
          norm_o <= q[31:0];
          sat_o  <= 1'b0;
        end
      end
    end
  end

endmodule

// File: hw/rtl/ldpm_math.sv
// Fourteen-stage distortion datapath: radial and tangential terms, then pixel mapping.
// Every product is registered before use. Depends on ldpm_pkg.
module ldpm_math (
  input  logic                clk_i,
  input  logic                en_i,
  input  ldpm_pkg::ldpm_cfg_t cfg_i,
  input  logic signed [31:0]  x_i,
  input  logic signed [31:0]  y_i,
  input  logic                sat_i,
  output logic signed [23:0]  dist_x_o,
  output logic signed [23:0]  dist_y_o,
  output logic                sat_o
);
  import ldpm_pkg::*;

  logic [23:0] fx, fy;
  assign fx = (cfg_i.focal_x == 24'd0) ? 24'd1 : cfg_i.focal_x;
  assign fy = (cfg_i.focal_y == 24'd0) ? 24'd1 : cfg_i.focal_y;

  logic signed [31:0] cx_q [10];
  logic signed [31:0] cy_q [10];
  logic               sf_q [14];

  // Stage registers.
  logic signed [63:0] pxx_q, pyy_q, pxy_q;
  logic signed [31:0] x2_q, y2_q, xy_q;
  logic signed [31:0] r2_q, x2b_q, y2b_q, xy3_q;
  logic signed [31:0] ax_q, ay_q, r2_4_q;
  logic signed [63:0] rr_q, k1p_q, pxy1_q, pxy2_q;
  logic signed [31:0] r4_q, t1_q, m1_q, m2_q, r2_5_q;
  logic signed [63:0] qx_q, qy_q;
  logic signed [63:0] r6p_q, k2p_q;
  logic signed [31:0] qxs_q, qys_q, t1_6_q, m1_6_q, m2_6_q;
  logic signed [31:0] r6_q, t2_q, tx_q, ty_q, t1_7_q;
  logic signed [63:0] k3p_q;
  logic signed [31:0] t1_8_q, t2_8_q, tx_8_q, ty_8_q;
  logic signed [31:0] t3_q, t1_9_q, t2_9_q, tx_9_q, ty_9_q;
  logic signed [31:0] rad_q, tx_10_q, ty_10_q;
  logic signed [63:0] mx_q, my_q;
  logic signed [31:0] tx_11_q, ty_11_q;
  logic signed [31:0] xd_q, yd_q;
  logic signed [56:0] ox_q, oy_q;

  // Combinational results of each stage.
  logic [32:0] x2_r, y2_r, xy_r, r2_r, ax_r, ay_r;
  logic [32:0] r4_r, t1_r, m1_r, m2_r, qxs_r, qys_r;
  logic [32:0] r6_r, t2_r, tx_r, ty_r, t3_r, rad_r;
  logic [32:0] mxs_r, mys_r, xd_r, yd_r;
  logic signed [29:0] ox_s, oy_s;
  logic signed [23:0] ox_c, oy_c;
  logic               ox_f, oy_f;

  assign x2_r  = mulq_fin(pxx_q);
  assign y2_r  = mulq_fin(pyy_q);
  assign xy_r  = mulq_fin(pxy_q);
  assign r2_r  = sat_s36(36'(x2_q) + 36'(y2_q));
  assign ax_r  = sat_s36(36'(r2_q) + (36'(x2b_q) <<< 1));
  assign ay_r  = sat_s36(36'(r2_q) + (36'(y2b_q) <<< 1));
  assign r4_r  = mulq_fin(rr_q);
  assign t1_r  = mulq_fin(k1p_q);
  assign m1_r  = mulq_fin(pxy1_q);
  assign m2_r  = mulq_fin(pxy2_q);
  assign qxs_r = mulq_fin(qx_q);
  assign qys_r = mulq_fin(qy_q);
  assign r6_r  = mulq_fin(r6p_q);
  assign t2_r  = mulq_fin(k2p_q);
  assign tx_r  = sat_s36((36'(m1_6_q) <<< 1) + 36'(qxs_q));
  assign ty_r  = sat_s36((36'(m2_6_q) <<< 1) + 36'(qys_q));
  assign t3_r  = mulq_fin(k3p_q);
  assign rad_r = sat_s36(36'(QOne) + 36'(t1_9_q) + 36'(t2_9_q) + 36'(t3_q));
  assign mxs_r = mulq_fin(mx_q);
  assign mys_r = mulq_fin(my_q);
  assign xd_r  = sat_s36(36'($signed(mxs_r[31:0])) + 36'(tx_11_q));
  assign yd_r  = sat_s36(36'($signed(mys_r[31:0])) + 36'(ty_11_q));

  // The floored pixel value is signed, so it is sign extended before the center is added.
  assign ox_s = 30'($signed(ox_q[56:28])) + $signed({10'd0, cfg_i.center_x});
  assign oy_s = 30'($signed(oy_q[56:28])) + $signed({10'd0, cfg_i.center_y});

  always_comb begin
    ox_f = 1'b1;
    oy_f = 1'b1;
    if (ox_s > 30'sd8388607) begin
      ox_c = 24'sh7FFFFF;
    end else if (ox_s < -30'sd8388608) begin
      ox_c = 24'sh800000;
    end else begin
      ox_c = ox_s[23:0];
      ox_f = 1'b0;
    end
    if (oy_s > 30'sd8388607) begin
      oy_c = 24'sh7FFFFF;
    end else if (oy_s < -30'sd8388608) begin
      oy_c = 24'sh800000;
    end else begin
      oy_c = oy_s[23:0];
      oy_f = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= x_i;
      cy_q[0] <= y_i;
      for (int i = 1; i < 10; i++) begin
        cx_q[i] <= cx_q[i-1];
        cy_q[i] <= cy_q[i-1];
      end
      // Stage 1
      pxx_q <= x_i * x_i;
      pyy_q <= y_i * y_i;
      pxy_q <= x_i * y_i;
      sf_q[0] <= sat_i;
      // Stage 2
      x2_q <= x2_r[31:0];
      y2_q <= y2_r[31:0];
      xy_q <= xy_r[31:0];
      sf_q[1] <= sf_q[0] | x2_r[32] | y2_r[32] | xy_r[32];
      // Stage 3
      r2_q  <= r2_r[31:0];
      x2b_q <= x2_q;
      y2b_q <= y2_q;
      xy3_q <= xy_q;
      sf_q[2] <= sf_q[1] | r2_r[32];
      // Stage 4
      ax_q   <= ax_r[31:0];
      ay_q   <= ay_r[31:0];
      rr_q   <= r2_q * r2_q;
      k1p_q  <= cfg_i.k1 * r2_q;
      pxy1_q <= cfg_i.p1 * xy3_q;
      pxy2_q <= cfg_i.p2 * xy3_q;
      r2_4_q <= r2_q;
      sf_q[3] <= sf_q[2] | ax_r[32] | ay_r[32];
      // Stage 5
      r4_q   <= r4_r[31:0];
      t1_q   <= t1_r[31:0];
      m1_q   <= m1_r[31:0];
      m2_q   <= m2_r[31:0];
      qx_q   <= cfg_i.p2 * ax_q;
      qy_q   <= cfg_i.p1 * ay_q;
      r2_5_q <= r2_4_q;
      sf_q[4] <= sf_q[3] | r4_r[32] | t1_r[32] | m1_r[32] | m2_r[32];
      // Stage 6
      r6p_q  <= r4_q * r2_5_q;
      k2p_q  <= cfg_i.k2 * r4_q;
      qxs_q  <= qxs_r[31:0];
      qys_q  <= qys_r[31:0];
      t1_6_q <= t1_q;
      m1_6_q <= m1_q;
      m2_6_q <= m2_q;
      sf_q[5] <= sf_q[4] | qxs_r[32] | qys_r[32];
      // Stage 7
      r6_q   <= r6_r[31:0];
      t2_q   <= t2_r[31:0];
      tx_q   <= tx_r[31:0];
      ty_q   <= ty_r[31:0];
      t1_7_q <= t1_6_q;
      sf_q[6] <= sf_q[5] | r6_r[32] | t2_r[32] | tx_r[32] | ty_r[32];
      // Stage 8
      k3p_q  <= cfg_i.k3 * r6_q;
      t1_8_q <= t1_7_q;
      t2_8_q <= t2_q;
      tx_8_q <= tx_q;
      ty_8_q <= ty_q;
      sf_q[7] <= sf_q[6];
      // Stage 9
      t3_q   <= t3_r[31:0];
      t1_9_q <= t1_8_q;
      t2_9_q <= t2_8_q;
      tx_9_q <= tx_8_q;
      ty_9_q <= ty_8_q;
      sf_q[8] <= sf_q[7] | t3_r[32];
      // Stage 10
      rad_q   <= rad_r[31:0];
      tx_10_q <= tx_9_q;
      ty_10_q <= ty_9_q;
      sf_q[9] <= sf_q[8] | rad_r[32];
      // Stage 11
      mx_q    <= cx_q[9] * rad_q;
      my_q    <= cy_q[9] * rad_q;
      tx_11_q <= tx_10_q;
      ty_11_q <= ty_10_q;
      sf_q[10] <= sf_q[9];
      // Stage 12
      xd_q <= xd_r[31:0];
      yd_q <= yd_r[31:0];
      sf_q[11] <= sf_q[10] | mxs_r[32] | mys_r[32] | xd_r[32] | yd_r[32];
      // Stage 13
      ox_q <= xd_q * $signed({1'b0, fx});
      oy_q <= yd_q * $signed({1'b0, fy});
      sf_q[12] <= sf_q[11];
      // Stage 14
      dist_x_o <= ox_c;
      dist_y_o <= oy_c;
      sf_q[13] <= sf_q[12] | ox_f | oy_f;
    end
  end

  assign sat_o = sf_q[13];

endmodule

// File: hw/rtl/lens_distortion_point_map.sv
// Lens distortion point map, five-coefficient radial and tangential model.
// Throughput: one coordinate beat per clock; the whole pipeline holds while a finished
// beat sits at the output and the consumer stalls. The divider's per-bit stages set
// the depth.
// Reset clears the valid bits and loads focal lengths of 256 (1.0 at the default FRAC_BITS) with all else zero.
module lens_distortion_point_map #(
  parameter int PIXEL_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [5:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIXEL_BITS-1:0] pixel_x_i,
  input  logic [PIXEL_BITS-1:0] pixel_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [23:0]    dist_x_o,
  output logic signed [23:0]    dist_y_o,
  output logic                  saturated_o
);
  import ldpm_pkg::*;

  // The normalizer spends one stage on the difference, one per quotient bit and one
  // to saturate; the datapath adds fourteen more.
  localparam int MW  = (PIXEL_BITS + FRAC_BITS > 20) ? PIXEL_BITS + FRAC_BITS : 20;
  localparam int LAT = MW + QShift + 2 + 14;

  ldpm_cfg_t          cfg;
  logic               adv;
  logic [LAT-1:0]     vld_q;
  logic signed [31:0] nx, ny;
  logic               sx, sy;

  // The whole pipeline moves together; it holds only while a finished beat
  // sits at the output and the consumer stalls.
  assign adv         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[LAT-1];

  ldpm_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  ldpm_norm #(.PIXEL_BITS(PIXEL_BITS), .FRAC_BITS(FRAC_BITS)) u_norm_x (
    .clk_i, .en_i(adv), .pix_i(pixel_x_i), .center_i(cfg.center_x),
    .focal_i(cfg.focal_x), .norm_o(nx), .sat_o(sx)
  );

  ldpm_norm #(.PIXEL_BITS(PIXEL_BITS), .FRAC_BITS(FRAC_BITS)) u_norm_y (
    .clk_i, .en_i(adv), .pix_i(pixel_y_i), .center_i(cfg.center_y),
    .focal_i(cfg.focal_y), .norm_o(ny), .sat_o(sy)
  );

  ldpm_math u_math (
    .clk_i, .en_i(adv), .cfg_i(cfg), .x_i(nx), .y_i(ny), .sat_i(sx | sy),
    .dist_x_o, .dist_y_o, .sat_o(saturated_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // A held pipeline keeps every valid bit in place.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q)) else $error("valid bits moved during a hold");

  // An accepted beat occupies the first stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0]) else $error("accepted beat lost");

  // An advancing cycle without input leaves a bubble in the first stage.
  a_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !in_valid_i) |=> !vld_q[0]) else $error("beat invented at entry");

endmodule
